>>> hw/rtl/mhx_pkg.sv
`default_nettype none

package mhx_pkg;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;

  localparam logic [1:0] WS_CODE_SP = 2'd0;
  localparam logic [1:0] WS_CODE_VT = 2'd1;
  localparam logic [1:0] WS_CODE_FF = 2'd2;

  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  typedef enum logic [1:0] {
    PH_LF    = 2'd0,
    PH_FLUSH = 2'd1,
    PH_BYTE  = 2'd2,
    PH_END   = 2'd3
  } phase_e;

  typedef struct packed {
    logic       emit_lf;
    logic       wr;
    logic [1:0] code;
    logic       emit_byte;
    logic [7:0] data;
    logic       is_end;
    logic       ovf;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       ovf;
  } res_t;

  function automatic logic [7:0] ws_byte(input logic [1:0] code);
    logic [7:0] b;
    case (code)
      WS_CODE_VT: b = CH_VT;
      WS_CODE_FF: b = CH_FF;
      default:    b = CH_SP;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mhx_ram.sv
`default_nettype none

module mhx_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> hw/rtl/mhx_fifo.sv
`default_nettype none

module mhx_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire T                           data_i,
  output      logic                       full_o,
  input  wire logic                       pop_i,
  output      T                           data_o,
  output      logic                       empty_o,
  output      logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  T                mem_q [DEPTH];
  logic [PW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH-1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH-1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mhx_front.sv
`default_nettype none

module mhx_front
  import mhx_pkg::*;
#(
  parameter int WS_DEPTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          req_type_i,
  input  wire logic [7:0]                    data_byte_i,
  output      logic                          cmd_push_o,
  output      cmd_t                          cmd_o,
  output      logic [$clog2(WS_DEPTH+1)-1:0] cnt_o
);

  localparam int CW = $clog2(WS_DEPTH+1);

  logic          done_q, done_d;
  logic          text_q, text_d;
  logic          lstart_q, lstart_d;
  logic          nlh_q, nlh_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] wcnt_q, wcnt_d;

  always_comb begin
    logic [7:0] b2;
    logic       is_ws;
    done_d     = done_q;
    text_d     = text_q;
    lstart_d   = lstart_q;
    nlh_d      = nlh_q;
    ovf_d      = ovf_q;
    wcnt_d     = wcnt_q;
    cmd_o      = '0;
    cnt_o      = '0;
    cmd_push_o = 1'b0;
    b2         = (data_byte_i == CH_TAB) ? CH_SP : data_byte_i;
    is_ws      = (b2 == CH_SP) || (b2 == CH_VT) || (b2 == CH_FF);
    if (in_valid_i) begin
      if (req_type_i) begin
        cmd_o.emit_lf = !done_q && nlh_q;
        cmd_o.is_end  = 1'b1;
        cmd_o.ovf     = ovf_q;
        cmd_push_o    = 1'b1;
        done_d        = 1'b0;
        text_d        = 1'b0;
        lstart_d      = 1'b1;
        nlh_d         = 1'b0;
        ovf_d         = 1'b0;
        wcnt_d        = '0;
      end else if (!done_q && (data_byte_i != CH_NUL)) begin
        if (lstart_q) begin
          lstart_d      = 1'b0;
          nlh_d         = 1'b0;
          cmd_o.emit_lf = nlh_q && (data_byte_i != CH_SP) && (data_byte_i != CH_TAB);
        end
        if (data_byte_i == CH_LF) begin
          if (!text_q) begin
            done_d = 1'b1;
          end else begin
            nlh_d    = 1'b1;
            lstart_d = 1'b1;
            text_d   = 1'b0;
            wcnt_d   = '0;
          end
          cmd_push_o = cmd_o.emit_lf;
        end else if (data_byte_i == CH_CR) begin
          cmd_push_o = cmd_o.emit_lf;
        end else if (!text_q && is_ws) begin
          if (wcnt_q < CW'(WS_DEPTH)) begin
            cmd_o.wr   = 1'b1;
            cmd_o.code = (b2 == CH_SP) ? WS_CODE_SP :
                         ((b2 == CH_VT) ? WS_CODE_VT : WS_CODE_FF);
            cnt_o      = wcnt_q;
            wcnt_d     = wcnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          cmd_push_o = cmd_o.emit_lf || cmd_o.wr;
        end else begin
          cnt_o           = text_q ? '0 : wcnt_q;
          wcnt_d          = '0;
          text_d          = 1'b1;
          cmd_o.emit_byte = 1'b1;
          cmd_o.data      = b2;
          cmd_push_o      = 1'b1;
        end
        cmd_o.ovf = ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q   <= 1'b0;
      text_q   <= 1'b0;
      lstart_q <= 1'b1;
      nlh_q    <= 1'b0;
      ovf_q    <= 1'b0;
      wcnt_q   <= '0;
    end else begin
      done_q   <= done_d;
      text_q   <= text_d;
      lstart_q <= lstart_d;
      nlh_q    <= nlh_d;
      ovf_q    <= ovf_d;
      wcnt_q   <= wcnt_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mhx_back.sv
`default_nettype none

module mhx_back
  import mhx_pkg::*;
#(
  parameter int WS_DEPTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cmd_valid_i,
  input  wire cmd_t                          cmd_i,
  input  wire logic [$clog2(WS_DEPTH+1)-1:0] cnt_i,
  output      logic                          cmd_pop_o,
  output      res_t                          res_o,
  output      logic                          res_empty_o,
  input  wire logic                          res_pop_i
);

  localparam int CW  = $clog2(WS_DEPTH+1);
  localparam int IW  = $clog2(WS_DEPTH);
  localparam int OCW = $clog2(OUT_DEPTH+1);

  phase_e        phase_q, phase_d;
  logic [CW-1:0] idx_q, idx_d;

  logic          s1_v_q, s1_v_d;
  logic          s1_ram_q, s1_ram_d;
  res_t          s1_q, s1_d;

  logic [1:0]    rdata;
  logic          we;
  logic [OCW-1:0] occ;
  logic          space;
  res_t          res_in;
  logic          res_full;

  assign space = ({1'b0, occ} + {{OCW{1'b0}}, s1_v_q}) < (OCW+1)'(OUT_DEPTH);

  always_comb begin
    logic act_lf, fl_pend, act_fl, by_pend, act_by, act_en, need_out, go, rem;
    act_lf   = (phase_q == PH_LF) && cmd_i.emit_lf;
    fl_pend  = (phase_q <= PH_FLUSH) && !cmd_i.wr && (idx_q < cnt_i);
    act_fl   = !act_lf && fl_pend;
    by_pend  = (phase_q <= PH_BYTE) && cmd_i.emit_byte;
    act_by   = !act_lf && !fl_pend && by_pend;
    act_en   = !act_lf && !fl_pend && !by_pend && cmd_i.is_end;
    need_out = act_lf || act_fl || act_by || act_en;
    go       = cmd_valid_i && (!need_out || space);

    phase_d  = phase_q;
    idx_d    = idx_q;
    rem      = 1'b0;
    s1_d     = '0;
    s1_d.ovf = cmd_i.ovf;
    s1_ram_d = 1'b0;
    if (act_lf) begin
      s1_d.data  = CH_LF;
      s1_d.valid = 1'b1;
      rem        = (!cmd_i.wr && (cnt_i != '0)) || cmd_i.emit_byte || cmd_i.is_end;
      phase_d    = PH_FLUSH;
      idx_d      = '0;
    end else if (act_fl) begin
      s1_d.valid = 1'b1;
      s1_ram_d   = 1'b1;
      rem        = (CW'(idx_q + 1'b1) < cnt_i) || cmd_i.emit_byte || cmd_i.is_end;
      phase_d    = PH_FLUSH;
      idx_d      = idx_q + 1'b1;
    end else if (act_by) begin
      s1_d.data  = cmd_i.data;
      s1_d.valid = 1'b1;
      rem        = cmd_i.is_end;
      phase_d    = PH_END;
    end else if (act_en) begin
      s1_d.last = 1'b1;
    end

    s1_v_d    = go && need_out;
    cmd_pop_o = go && !rem;
    we        = cmd_pop_o && cmd_i.wr;
    if (!go) begin
      phase_d = phase_q;
      idx_d   = idx_q;
    end else if (!rem) begin
      phase_d = PH_LF;
      idx_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LF;
      idx_q   <= '0;
      s1_v_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      s1_v_q  <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q     <= s1_d;
    s1_ram_q <= s1_ram_d;
  end

  mhx_ram #(
    .WIDTH (2),
    .DEPTH (WS_DEPTH)
  ) u_ws_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_i[IW-1:0]),
    .wdata_i (cmd_i.code),
    .raddr_i (idx_q[IW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    res_in = s1_q;
    if (s1_ram_q) begin
      res_in.data = ws_byte(rdata);
    end
  end

  mhx_fifo #(
    .T     (res_t),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s1_v_q),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (res_pop_i),
    .data_o  (res_o),
    .empty_o (res_empty_o),
    .count_o (occ)
  );

  logic unused_full;
  assign unused_full = res_full;

endmodule

`default_nettype wire

>>> hw/rtl/mail_header_extract_unfold.sv
// Channel  | Direction | Handshake          | Words
// ---------+-----------+--------------------+----------------------------------------------
// input    | in        | push / full        | req_type_i, data_byte_i
// result   | out       | empty / pop        | out_byte_o, byte_valid_o, stream_end_o,
//          |           |                    | ws_overflow_o
//
// The front accepts one input word per cycle while its four-entry command queue has room.
// The back turns each command into results at one result per cycle while the result queue
// has room; a line whose first printable byte releases n buffered whitespace codes gives n
// results for them ahead of the byte, each one a read of the whitespace RAM.
// Each result is registered in the stage-one register, then written into the result queue.
// Reset is asynchronous and takes effect at once; the whitespace RAM needs no clearing pass.
// A stalled result side fills the four-entry result queue, then the command queue, then full.
`default_nettype none

module mail_header_extract_unfold
  import mhx_pkg::*;
#(
  parameter int WS_DEPTH = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output      logic       full,
  input  wire logic       req_type_i,
  input  wire logic [7:0] data_byte_i,
  output      logic       empty,
  input  wire logic       pop,
  output      logic [7:0] out_byte_o,
  output      logic       byte_valid_o,
  output      logic       stream_end_o,
  output      logic       ws_overflow_o
);

  localparam int CW   = $clog2(WS_DEPTH+1);
  localparam int CMDW = $bits(cmd_t) + CW;

  logic            f_push;
  cmd_t            f_cmd;
  logic [CW-1:0]   f_cnt;
  logic [CMDW-1:0] q_out;
  logic            q_empty;
  logic            b_pop;
  res_t            res;
  logic [$clog2(CMD_DEPTH+1)-1:0] q_count;

  mhx_front #(
    .WS_DEPTH (WS_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (push && !full),
    .req_type_i  (req_type_i),
    .data_byte_i (data_byte_i),
    .cmd_push_o  (f_push),
    .cmd_o       (f_cmd),
    .cnt_o       (f_cnt)
  );

  mhx_fifo #(
    .T     (logic [CMDW-1:0]),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  ({f_cmd, f_cnt}),
    .full_o  (full),
    .pop_i   (b_pop),
    .data_o  (q_out),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  mhx_back #(
    .WS_DEPTH (WS_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_empty),
    .cmd_i       (q_out[CMDW-1:CW]),
    .cnt_i       (q_out[CW-1:0]),
    .cmd_pop_o   (b_pop),
    .res_o       (res),
    .res_empty_o (empty),
    .res_pop_i   (pop)
  );

  logic unused_count;
  assign unused_count = ^q_count;

  assign out_byte_o    = res.data;
  assign byte_valid_o  = res.valid;
  assign stream_end_o  = res.last;
  assign ws_overflow_o = res.ovf;

endmodule

`default_nettype wire

>>> hw/rtl/mhx_checker.sv
`default_nettype none

module mhx_checker
  import mhx_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       push,
  input wire logic       full,
  input wire logic       req_type_i,
  input wire logic [7:0] data_byte_i,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_byte_o,
  input wire logic       byte_valid_o,
  input wire logic       stream_end_o,
  input wire logic       ws_overflow_o
);

  // The end word carries no header byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && stream_end_o) |-> (!byte_valid_o && (out_byte_o == CH_NUL)))
    else $error("end word carries a byte");

  // Every word without a byte is an end word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !byte_valid_o) |-> stream_end_o)
    else $error("empty word that is not an end word");

  // Header bytes never hold zero, carriage return or tab.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && byte_valid_o) |->
      ((out_byte_o != CH_NUL) && (out_byte_o != CH_CR) && (out_byte_o != CH_TAB)))
    else $error("forbidden byte in header output");

  // No result is waiting right after reset is released.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rst_ni && !$past(rst_ni)) |-> empty)
    else $error("result present after reset");

  logic unused_in;
  assign unused_in = push ^ full ^ req_type_i ^ (^data_byte_i) ^ pop ^ ws_overflow_o;

endmodule

bind mail_header_extract_unfold mhx_checker u_mhx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .push          (push),
  .full          (full),
  .req_type_i    (req_type_i),
  .data_byte_i   (data_byte_i),
  .empty         (empty),
  .pop           (pop),
  .out_byte_o    (out_byte_o),
  .byte_valid_o  (byte_valid_o),
  .stream_end_o  (stream_end_o),
  .ws_overflow_o (ws_overflow_o)
);

`default_nettype wire
